FILE: rtl/core/isqw_pkg.sv
// Shared types and constants for the interlocked square-wave drive.
// Used by every module in rtl/core; depends on nothing else.
package isqw_pkg;

    // Default tick rate of the incoming item stream
    localparam int TICKS_PER_SECOND_DEF = 1000;

    // Drive frequency limits in hertz
    localparam int FREQ_MIN = 66;
    localparam int FREQ_MAX = 150;
    localparam int FREQ_SPAN = FREQ_MAX - FREQ_MIN + 1;
    localparam int FREQ_IDX_W = $clog2(FREQ_SPAN);

    // Debounce timer width and saturation level
    localparam int TIMER_W = 16;
    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    // Register file geometry
    localparam int ADDR_W = 5;
    localparam int REG_IDX_W = 3;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_TICKS   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FREQ_SETTING     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_POL_HIGH         = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INTERLOCK_ENABLE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MODEL_KIND       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INPUT_PRESENT    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_OUTPUT_PRESENT   = 3'd6;

    // Operating modes
    typedef enum logic [1:0] {
        MODE_FREQ    = 2'd0,
        MODE_SERIAL  = 2'd1,
        MODE_DROP_IN = 2'd2,
        MODE_UNUSED  = 2'd3
    } mode_t;

    // Register reset values
    localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [15:0] FREQ_RESET     = 16'd66;

    // Programmed configuration
    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [15:0] freq_setting;
        logic        pol_high;
        logic        interlock_enable;
        mode_t       model_kind;
        logic        input_present;
        logic        output_present;
    } cfg_t;

    // Write event with the values that take effect on it
    typedef struct packed {
        logic wr;
        logic pol_high_next;
        logic output_present_next;
    } cfg_wr_t;

    // One result item
    typedef struct packed {
        logic [7:0] freq_in_use;
        logic       phase_now;
        logic       armed_now;
        logic       debounced_level;
        logic       pin_level;
    } res_t;

endpackage

FILE: rtl/core/isqw_cfg.sv
// Configuration register file with APB-style access, plus clamped frequency
// and half-period lookup. Depends on isqw_pkg.
module isqw_cfg #(
    parameter int TICKS_PER_SECOND = isqw_pkg::TICKS_PER_SECOND_DEF,
    parameter int WAIT_W = 3
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [isqw_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output isqw_pkg::cfg_t             cfg,
    output isqw_pkg::cfg_wr_t          cfg_wr,
    output logic [7:0]                 hz,
    output logic [WAIT_W-1:0]          half
);
    import isqw_pkg::*;

    cfg_t                  cfg_reg, cfg_next;
    logic [7:0]            hz_reg, hz_next;
    logic [WAIT_W-1:0]     half_reg, half_next;
    logic [REG_IDX_W-1:0]  idx;
    logic                  wr_en;
    logic                  listed;
    logic [7:0]            hz_clamp;
    logic [FREQ_IDX_W-1:0] tab_idx;
    logic [WAIT_W-1:0]     half_tab [FREQ_SPAN];

    // Half-period table, one entry per frequency in range
    for (genvar g = 0; g < FREQ_SPAN; g++) begin : g_half
        localparam int PER = TICKS_PER_SECOND / (FREQ_MIN + g);
        localparam int HLF = ((PER / 2) > 0) ? (PER / 2) : 1;
        assign half_tab[g] = WAIT_W'(HLF);
    end

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign listed = (idx <= REG_OUTPUT_PRESENT);

    // Clamp the frequency being written
    always_comb begin
        if (pwdata[15:0] < 16'(FREQ_MIN)) begin
            hz_clamp = 8'(FREQ_MIN);
        end else if (pwdata[15:0] > 16'(FREQ_MAX)) begin
            hz_clamp = 8'(FREQ_MAX);
        end else begin
            hz_clamp = pwdata[7:0];
        end
        tab_idx = FREQ_IDX_W'(hz_clamp - 8'(FREQ_MIN));
    end

    // Register write decode
    always_comb begin
        cfg_next  = cfg_reg;
        hz_next   = hz_reg;
        half_next = half_reg;
        if (wr_en) begin
            unique case (idx)
                REG_DEBOUNCE_TICKS: begin
                    cfg_next.debounce_ticks = pwdata[15:0];
                end
                REG_FREQ_SETTING: begin
                    cfg_next.freq_setting = pwdata[15:0];
                    hz_next   = hz_clamp;
                    half_next = half_tab[tab_idx];
                end
                REG_POL_HIGH:         cfg_next.pol_high = pwdata[0];
                REG_INTERLOCK_ENABLE: cfg_next.interlock_enable = pwdata[0];
                REG_MODEL_KIND:       cfg_next.model_kind = mode_t'(pwdata[1:0]);
                REG_INPUT_PRESENT:    cfg_next.input_present = pwdata[0];
                REG_OUTPUT_PRESENT:   cfg_next.output_present = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks   <= DEBOUNCE_RESET;
            cfg_reg.freq_setting     <= FREQ_RESET;
            cfg_reg.pol_high         <= 1'b1;
            cfg_reg.interlock_enable <= 1'b0;
            cfg_reg.model_kind       <= MODE_FREQ;
            cfg_reg.input_present    <= 1'b1;
            cfg_reg.output_present   <= 1'b1;
            hz_reg                   <= 8'(FREQ_MIN);
            half_reg                 <= half_tab[0];
        end else begin
            cfg_reg  <= cfg_next;
            hz_reg   <= hz_next;
            half_reg <= half_next;
        end
    end

    // Read back
    always_comb begin
        unique case (idx)
            REG_DEBOUNCE_TICKS:   prdata = {16'd0, cfg_reg.debounce_ticks};
            REG_FREQ_SETTING:     prdata = {16'd0, cfg_reg.freq_setting};
            REG_POL_HIGH:         prdata = {31'd0, cfg_reg.pol_high};
            REG_INTERLOCK_ENABLE: prdata = {31'd0, cfg_reg.interlock_enable};
            REG_MODEL_KIND:       prdata = {30'd0, cfg_reg.model_kind};
            REG_INPUT_PRESENT:    prdata = {31'd0, cfg_reg.input_present};
            REG_OUTPUT_PRESENT:   prdata = {31'd0, cfg_reg.output_present};
            default:              prdata = 32'd0;
        endcase
    end

    assign cfg                        = cfg_reg;
    assign hz                         = hz_reg;
    assign half                       = half_reg;
    assign cfg_wr.wr                  = wr_en && listed;
    assign cfg_wr.pol_high_next       = cfg_next.pol_high;
    assign cfg_wr.output_present_next = cfg_next.output_present;

endmodule

FILE: rtl/core/isqw_debounce.sv
// Input debounce filter: last raw level, debounced level and a saturating
// timer since the last raw change. Depends on isqw_pkg.
module isqw_debounce (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic                        raw_level,
    input  logic                        input_present,
    input  logic [isqw_pkg::TIMER_W-1:0] debounce_ticks,
    output logic                        level
);
    import isqw_pkg::*;

    logic               last_raw_reg, last_raw_next;
    logic               debounced_reg, debounced_next;
    logic [TIMER_W-1:0] since_reg, since_next;
    logic [TIMER_W-1:0] since_cur;

    // Restart the timer on a change, follow once it has run long enough
    always_comb begin
        last_raw_next  = last_raw_reg;
        debounced_next = debounced_reg;
        since_cur      = since_reg;
        if (input_present) begin
            if (raw_level != last_raw_reg) begin
                since_cur     = '0;
                last_raw_next = raw_level;
            end
            if (since_cur >= debounce_ticks) begin
                debounced_next = raw_level;
            end
        end
        since_next = (since_cur != TIMER_MAX) ? since_cur + 1'b1 : since_cur;
        level      = input_present & debounced_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg  <= 1'b0;
            debounced_reg <= 1'b0;
            since_reg     <= '0;
        end else if (step) begin
            last_raw_reg  <= last_raw_next;
            debounced_reg <= debounced_next;
            since_reg     <= since_next;
        end
    end

endmodule

FILE: rtl/core/isqw_drive.sv
// Arm flag with interlock, half-period toggle timer, phase and pin driver.
// Depends on isqw_pkg.
module isqw_drive #(
    parameter int WAIT_W = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              arm_request,
    input  logic              level,
    input  isqw_pkg::cfg_t    cfg,
    input  isqw_pkg::cfg_wr_t cfg_wr,
    input  logic [7:0]        hz,
    input  logic [WAIT_W-1:0] half,
    output isqw_pkg::res_t    res
);
    import isqw_pkg::*;

    logic              armed_reg, armed_next;
    logic              phase_reg, phase_next;
    logic              pin_reg, pin_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [7:0]        freq_reg, freq_next;
    logic [WAIT_W-1:0] wait_cur;

    // Advance one tick
    always_comb begin
        armed_next = arm_request | armed_reg;
        if (cfg.interlock_enable && level) begin
            armed_next = 1'b0;
        end
        phase_next = phase_reg;
        pin_next   = pin_reg;
        freq_next  = freq_reg;
        wait_cur   = wait_reg;
        if (cfg.model_kind == MODE_FREQ) begin
            freq_next = hz;
            if (wait_reg == '0) begin
                phase_next = ~phase_reg;
                if (cfg.output_present) begin
                    pin_next = (armed_next & phase_next) ^ ~cfg.pol_high;
                end
                wait_cur = half;
            end
        end
        wait_next = (wait_cur != '0) ? wait_cur - 1'b1 : wait_cur;
    end

    // Config writes disarm and park the pin at its off level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b0;
            phase_reg <= 1'b0;
            pin_reg   <= 1'b0;
            wait_reg  <= '0;
            freq_reg  <= '0;
        end else if (cfg_wr.wr) begin
            armed_reg <= 1'b0;
            if (cfg_wr.output_present_next) begin
                pin_reg <= ~cfg_wr.pol_high_next;
            end
        end else if (step) begin
            armed_reg <= armed_next;
            phase_reg <= phase_next;
            pin_reg   <= pin_next;
            wait_reg  <= wait_next;
            freq_reg  <= freq_next;
        end
    end

    assign res.pin_level       = pin_next;
    assign res.debounced_level = level;
    assign res.armed_now       = armed_next;
    assign res.phase_now       = phase_next;
    assign res.freq_in_use     = freq_next;

endmodule

FILE: rtl/core/interlocked_square_wave_drive.sv
// Top level of the interlocked square-wave drive: item channels, output
// register and configuration port. Depends on isqw_pkg, isqw_cfg,
// isqw_debounce and isqw_drive.
//
// Usage:
//   Each input item on the s_ channel is one tick and carries the raw sensor
//   level and an arm request. For every item accepted exactly one result item
//   leaves on the m_ channel: pin level, debounced level, armed flag, phase
//   and the clamped frequency in use.
//   m_tvalid rises in the cycle after acceptance. One item per cycle is
//   sustained while m_tready stays high: the tick update is a single
//   combinational pass over the state registers into the result register.
//   When the receiver stalls, the result register holds its item and
//   s_tready drops until it is taken; no item is lost or repeated.
//   Reset clears the filter, arm flag, phase and timer, parks the pin at the
//   off level and loads the register defaults. Any configuration write to a
//   listed register disarms the output and, with an output present, parks
//   the pin at the off level for the new polarity.
module interlocked_square_wave_drive #(
    parameter int TICKS_PER_SECOND = isqw_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // tdata: [0] raw_level, [1] arm_request, [7:2] zero
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,
    // tdata: [0] pin_level, [1] debounced_level, [2] armed_now,
    //        [3] phase_now, [11:4] freq_in_use, [15:12] zero
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [isqw_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import isqw_pkg::*;

    localparam int HALF_RAW = (TICKS_PER_SECOND / FREQ_MIN) / 2;
    localparam int HALF_MAX = (HALF_RAW > 0) ? HALF_RAW : 1;
    localparam int WAIT_W   = $clog2(HALF_MAX + 1);

    cfg_t              cfg;
    cfg_wr_t           cfg_wr;
    logic [7:0]        hz;
    logic [WAIT_W-1:0] half;
    logic              step;
    logic              level;
    res_t              res;
    logic              m_valid_reg;
    res_t              m_res_reg;

    assign pready   = 1'b1;
    assign s_tready = !m_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    isqw_cfg #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .WAIT_W           (WAIT_W)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr),
        .hz      (hz),
        .half    (half)
    );

    isqw_debounce u_debounce (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .raw_level      (s_tdata[0]),
        .input_present  (cfg.input_present),
        .debounce_ticks (cfg.debounce_ticks),
        .level          (level)
    );

    isqw_drive #(
        .WAIT_W (WAIT_W)
    ) u_drive (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .arm_request (s_tdata[1]),
        .level       (level),
        .cfg         (cfg),
        .cfg_wr      (cfg_wr),
        .hz          (hz),
        .half        (half),
        .res         (res)
    );

    // Hold the result item until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_res_reg.freq_in_use, m_res_reg.phase_now,
                       m_res_reg.armed_now, m_res_reg.debounced_level,
                       m_res_reg.pin_level};

endmodule
